### hw/rtl/bounded_id_set_table_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded id set table
// Clocked property checks with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ID_SET_TABLE_TOP_DEFINES_SVH
`define BOUNDED_ID_SET_TABLE_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define BIST_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BIST_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/bist_pkg.sv
// ----------------------------------------------------------------------------
// bist_pkg
// Shared types and constants of the bounded id set table.
// ----------------------------------------------------------------------------
`default_nettype none

package bist_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_W         = 32;
   localparam int ACT_W        = 2;
   localparam int COUNT_W      = 5;
   localparam int RSP_DATA_W   = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_POP    = 2'd2,
      ACT_CHECK  = 2'd3
   } act_type;

   typedef struct packed {
      logic               status;
      logic               found;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/bist_ram.sv
// ----------------------------------------------------------------------------
// bist_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bist_ram
   import bist_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int AW    = 4
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [AW-1:0]   wr_addr,
   input  wire logic [ID_W-1:0] wr_data,
   input  wire logic [AW-1:0]   rd_addr,
   output logic      [ID_W-1:0] rd_data
);

   logic [ID_W-1:0] mem [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/bist_seq.sv
// ----------------------------------------------------------------------------
// bist_seq
// Action sequencer: walks the store with one shared id comparator and one
// pointer incrementer, scanning, shifting and updating the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module bist_seq
   import bist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int AW       = 4,
   parameter int CNT_W    = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire act_type          start_act,
   input  wire logic [ID_W-1:0]  start_id,
   input  wire logic             slot_free,
   output logic                  idle,
   output logic                  done,
   output rsp_type               rsp,
   output logic      [CNT_W-1:0] used,
   output logic                  wr_en,
   output logic      [AW-1:0]    wr_addr,
   output logic      [ID_W-1:0]  wr_data,
   output logic      [AW-1:0]    rd_addr,
   input  wire logic [ID_W-1:0]  rd_data
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_FETCH    = 6'b000010,
      ST_MATCH    = 6'b000100,
      ST_SHIFT_RD = 6'b001000,
      ST_SHIFT_WR = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   act_type          act_ff, act_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             status_ff, status_in;
   logic             found_ff, found_in;

   // shared unit: pointer step, end-of-list compare, id compare
   logic [CNT_W-1:0] ptr_nxt;
   logic             at_end;
   logic             id_hit;

   assign ptr_nxt = ptr_ff + CNT_W'(1);
   assign at_end  = (ptr_nxt == used_ff);
   assign id_hit  = (rd_data == id_ff);

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      id_in     = id_ff;
      ptr_in    = ptr_ff;
      used_in   = used_ff;
      status_in = status_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = ptr_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in    = start_act;
               id_in     = start_id;
               ptr_in    = '0;
               status_in = 1'b0;
               found_in  = 1'b0;
               state_in  = ST_DONE;
               unique case (start_act)
                  ACT_APPEND: begin
                     if (start_id == '0 || used_ff >= CNT_W'(CAPACITY)) begin
                        status_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = used_ff[AW-1:0];
                        wr_data = start_id;
                        used_in = used_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP: begin
                     if (used_ff == '0) begin
                        status_in = 1'b1;
                     end else begin
                        used_in = used_ff - CNT_W'(1);
                     end
                  end
                  ACT_REMOVE, ACT_CHECK: begin
                     if (start_id == '0 || used_ff == '0) begin
                        status_in = 1'b1;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: status_in = 1'b1;
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            if (id_hit) begin
               if (act_ff == ACT_CHECK) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end else if (at_end) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               ptr_in   = ptr_nxt;
               state_in = ST_FETCH;
            end
         end
         ST_SHIFT_RD: begin
            // pull the entry above the gap, or close out at the list end
            rd_addr = ptr_nxt[AW-1:0];
            if (at_end) begin
               used_in  = used_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            ptr_in   = ptr_nxt;
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      id_ff     <= id_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign done       = (state_ff == ST_DONE);
   assign rsp.status = status_ff;
   assign rsp.found  = found_ff;
   assign rsp.count  = COUNT_W'(used_ff);
   assign used       = used_ff;

endmodule

`default_nettype wire

### hw/rtl/bounded_id_set_table_top.sv
// Sequencing: append, pop and rejected beats go from idle straight to the done state;
// a check fetches and matches each entry in turn, and a remove also moves each later
// entry down one place by a read and a write, then lowers the fill count.
// Throughput: one beat at a time; the store ports and the shared comparator
// are walked by the sequencer, and the next beat is taken once it returns to idle.
// Reset (synchronous, active high) empties the list and drops any pending result.
// ----------------------------------------------------------------------------
// bounded_id_set_table_top
// Ordered table of up to CAPACITY nonzero ids with append, remove, pop and
// membership check; one status beat per request beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_id_set_table_top_defines.svh"

module bounded_id_set_table_top
   import bist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ID_W-1:0]       req_tdata,  // [31:0] id
   input  wire logic [ACT_W-1:0]      req_tuser,  // [1:0] action
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata   // [0] status, [1] found,
                                                  // [6:2] count, [7] zero
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             seq_idle;
   logic             seq_done;
   rsp_type          seq_rsp;
   logic [CNT_W-1:0] used;
   logic             slot_free;
   logic             req_accept;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ID_W-1:0]  wr_data;
   logic [AW-1:0]    rd_addr;
   logic [ID_W-1:0]  rd_data;

   // Output register: holds one finished beat so the sequencer can go back
   // to idle and take the next request while the result waits.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // Take a request only while the sequencer is idle and out of reset.
   assign req_tready = seq_idle & !reset;
   assign req_accept = req_tvalid & req_tready;

   // The output slot is free when empty or being drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   bist_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .start_act (act_type'(req_tuser)),
      .start_id  (req_tdata),
      .slot_free (slot_free),
      .idle      (seq_idle),
      .done      (seq_done),
      .rsp       (seq_rsp),
      .used      (used),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bist_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Load a finished beat into the slot, drop the old one once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.count, rsp_data_ff.found, rsp_data_ff.status};

   // Hold last cycle's fill count for the step check.
   logic [CNT_W-1:0] used_last_ff;
   logic             used_step_ok;
   logic             rsp_found;

   always_ff @(posedge clock) begin
      used_last_ff <= used;
   end

   assign used_step_ok = (used == used_last_ff) || (used == used_last_ff + CNT_W'(1))
                         || (used + CNT_W'(1) == used_last_ff);
   assign rsp_found    = rsp_tvalid && rsp_data_ff.found;

   // The fill count never passes the table size.
   `BIST_ASSERT(a_used_bound, clock, reset, used <= CNT_W'(CAPACITY), "fill above capacity")

   // A request beat moves the sequencer out of idle: no back-to-back acceptance.
   `BIST_ASSERT(a_one_at_a_time, clock, reset, req_accept |=> !req_tready, "taken while busy")

   // A found id always reports success.
   `BIST_ASSERT(a_found_ok, clock, reset, rsp_found |-> !rsp_data_ff.status, "found but error")

   // The fill count moves by at most one per cycle.
   `BIST_ASSERT(a_used_step, clock, reset, used_step_ok, "fill count jumped")

endmodule

`default_nettype wire

### dv/tb_bounded_id_set_table_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_id_set_table_top
// Self-checking bench for the bounded id set table: a directed pass over
// the empty, zero-id, full and duplicate cases, then random action streams
// that fill and drain the table under four sender and receiver idling phases.
// Every response beat is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb_bounded_id_set_table_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bist_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEF;
   // worst beat: a remove that walks every held entry
   localparam int BEAT_CYCLES = 2 * CAPACITY + 2;
   localparam int STALL_LIMIT = 40 * BEAT_CYCLES;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ID_W-1:0]       req_tdata = '0;   // [31:0] id
   logic [ACT_W-1:0]      req_tuser = '0;   // [1:0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [0] status, [1] found, [6:2] count, [7] zero

   // idling knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // shadow copy of the table, oldest id first
   logic [ID_W-1:0] held_ids [CAPACITY];
   int              held_count = 0;

   // responses owed by the block, oldest first
   rsp_type         owed_status [$];
   int              mismatch_count = 0;

   // ids reused often so that removes and checks hit
   logic [ID_W-1:0] id_pool [8] = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                                    32'h0000_0007, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'hFFFF_FFFE, 32'hFFFF_FFFF};

   bounded_id_set_table_top #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Table model
   // ------------------------------------------------------------------------

   // position of the first held copy of an id, or -1
   function automatic int locate_id(logic [ID_W-1:0] id);
      int i;
      for (i = 0; i < held_count; i++) begin
         if (held_ids[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   // apply one action to the shadow table and return the response it earns
   function automatic rsp_type table_apply(act_type act, logic [ID_W-1:0] id);
      rsp_type r;
      int      pos;
      int      j;
      r.status = 1'b0;
      r.found  = 1'b0;
      case (act)
         ACT_APPEND: begin
            if (id == '0 || held_count >= CAPACITY) begin
               r.status = 1'b1;
            end else begin
               held_ids[held_count] = id;
               held_count++;
            end
         end
         ACT_REMOVE: begin
            pos = (id == '0) ? -1 : locate_id(id);
            if (pos < 0) begin
               r.status = 1'b1;
            end else begin
               // close the gap: later ids move down one place
               for (j = pos; j + 1 < held_count; j++) begin
                  held_ids[j] = held_ids[j + 1];
               end
               held_count--;
            end
         end
         ACT_POP: begin
            if (held_count == 0) begin
               r.status = 1'b1;
            end else begin
               held_count--;
            end
         end
         default: begin
            // membership check: a zero id is never found
            r.found  = (id != '0) && (locate_id(id) >= 0);
            r.status = ~r.found;
         end
      endcase
      r.count = COUNT_W'(held_count);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // drive one request beat, idling first at the phase rate; valid stays
   // high on return so that back-to-back beats never drop it
   task automatic send_action(act_type act, logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= id;
      req_tuser  <= act;
      do begin
         @(posedge clock);
      end while (!req_tready);
      owed_status.push_back(table_apply(act, id));
   endtask

   // hold off the sender until every owed response is back, then let the
   // block settle for one worst-case beat
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (BEAT_CYCLES) @(posedge clock);
   endtask

   // an id already held in half the picks while any are held, else pooled, fully random or zero
   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 5) begin
         return '0;
      end else if (r < 55 && held_count > 0) begin
         return held_ids[$urandom_range(held_count - 1)];
      end else if (r < 80) begin
         return id_pool[$urandom_range(7)];
      end
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: stall at the phase rate and check each accepted beat
   // ------------------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_status.size() == 0) begin
            report_mismatch("unexpected response beat", rsp_tdata, -1);
         end else begin
            want = owed_status.pop_front();
            if (rsp_tdata[0] !== want.status) begin
               report_mismatch("status", rsp_tdata[0], want.status);
            end
            if (rsp_tdata[1] !== want.found) begin
               report_mismatch("found", rsp_tdata[1], want.found);
            end
            if (rsp_tdata[6:2] !== want.count) begin
               report_mismatch("count", rsp_tdata[6:2], want.count);
            end
            if (rsp_tdata[7] !== 1'b0) begin
               report_mismatch("padding bit", rsp_tdata[7], 0);
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when no beat moves on either side for too long
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // empty table: pop ignores its id, lookups miss, zero ids are rejected
   task automatic test_empty_and_zero();
      send_action(ACT_POP, 32'hFFFF_FFFF);
      send_action(ACT_REMOVE, 32'h0000_0005);
      send_action(ACT_CHECK, 32'h0000_0005);
      send_action(ACT_APPEND, '0);
      send_action(ACT_REMOVE, '0);
      send_action(ACT_CHECK, '0);
   endtask

   // fill to capacity with extreme and duplicate ids, then overflow once
   task automatic test_fill_and_overflow();
      int i;
      send_action(ACT_APPEND, 32'h0000_0001);
      send_action(ACT_APPEND, 32'hFFFF_FFFF);
      send_action(ACT_APPEND, 32'h0000_0001);   // duplicates are allowed
      for (i = 3; i < CAPACITY; i++) begin
         send_action(ACT_APPEND, 32'h1000_0000 + i);
      end
      send_action(ACT_APPEND, 32'h5A5A_5A5A);   // table full
   endtask

   // remove from the middle, remove the first of two copies, check, pop
   task automatic test_remove_and_check();
      send_action(ACT_REMOVE, 32'hFFFF_FFFF);
      send_action(ACT_REMOVE, 32'h0000_0001);
      send_action(ACT_CHECK, 32'h0000_0001);    // second copy still held
      send_action(ACT_CHECK, 32'hFFFF_FFFF);    // gone
      send_action(ACT_POP, '0);
   endtask

   // random actions; append_pct steers the table toward full or empty
   task automatic run_random_actions(int n, int append_pct);
      int      i;
      int      r;
      act_type act;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < append_pct) begin
            act = ACT_APPEND;
         end else begin
            case ($urandom_range(2))
               0:       act = ACT_REMOVE;
               1:       act = ACT_POP;
               default: act = ACT_CHECK;
            endcase
         end
         send_action(act, pick_id());
      end
   endtask

   // one idling phase: fill, optionally pause for a full drain, then empty
   task automatic test_random_phase(int send_pct, int recv_pct, bit with_pause);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      run_random_actions(75, 70);
      if (with_pause) begin
         hold_until_drained();
      end
      run_random_actions(75, 20);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_zero();
      test_fill_and_overflow();
      test_remove_and_check();

      test_random_phase(0, 0, 1'b0);
      test_random_phase(49, 0, 1'b1);
      test_random_phase(0, 49, 1'b0);
      test_random_phase(7, 7, 1'b0);

      // drop valid, collect every owed response, then allow late extras
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_until_drained();

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
